// ===== hdl/bdc_pkg.sv =====
// Shared types and constants for the button debounce and click detector.
// Depends on nothing; used by button_debounce_click_detector.
`timescale 1ns / 1ps
`default_nettype none

package bdc_pkg;

    // Click machine modes, encoded as the mode field reports them
    typedef enum logic [2:0] {
        MODE_RELEASED      = 3'd0,
        MODE_PRESSED       = 3'd1,
        MODE_PRESS_REL     = 3'd2,
        MODE_SECOND_PRESS  = 3'd3,
        MODE_HELD          = 3'd4,
        MODE_HELD_REL      = 3'd5,
        MODE_HELD_REPRESS  = 3'd6,
        MODE_SECOND_REL    = 3'd7
    } t_mode;

    // Register indexes on the configuration port (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_ACTIVE_LOW   = 3'd0,
        REG_DEBOUNCE_MS  = 3'd1,
        REG_PRESS_MS     = 3'd2,
        REG_CLICK_MS     = 3'd3,
        REG_INITIAL_MODE = 3'd4,
        REG_RSVD5        = 3'd5,
        REG_RSVD6        = 3'd6,
        REG_RSVD7        = 3'd7
    } t_reg_idx;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic        RST_ACTIVE_LOW   = 1'b1;
    localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd50;
    localparam logic [15:0] RST_PRESS_MS     = 16'd1000;
    localparam logic [15:0] RST_CLICK_MS     = 16'd400;
    localparam logic [2:0]  RST_INITIAL_MODE = 3'd0;

    // Event flags of one result word
    typedef struct packed {
        logic clicked;
        logic double_clicked;
        logic long_pressed;
        logic long_released;
        logic switched;
    } t_events;

endpackage

`default_nettype wire

// ===== hdl/button_debounce_click_detector.sv =====
// Button debounce and click detector: top level, one module.
// Depends on bdc_pkg (mode and register codes, reset values, event struct).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// ------    ---------  ----------------------  ---------------------------------------
// poll in   in         i_in_valid / o_in_stall i_raw_level, i_now_ms
// result    out        o_out_valid/i_out_stall o_clicked .. o_any_event, o_mode,
//                                              o_stable_level
// config    in         psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// A poll word is captured in an input register, evaluated in one pass (debounce,
// two wrapping time subtractions, the click machine) and lands in the result
// register when it can advance; one word per cycle is sustained while the
// result side does not stall. The input stage refills in the same cycle that it
// hands its word onward, so a waiting result does not block the next poll;
// o_in_stall rises only when both stages are full and the result side stalls.
// Reset (synchronous, active low) loads the documented register defaults,
// mode released, stable and previous levels at the released level, timers zero.

module button_debounce_click_detector #(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    // poll input
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_raw_level,
    input  wire logic [31:0]                 i_now_ms,

    // result output
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_clicked,
    output logic                             o_double_clicked,
    output logic                             o_long_pressed,
    output logic                             o_long_released,
    output logic                             o_switched,
    output logic                             o_any_event,
    output logic [2:0]                       o_mode,
    output logic                             o_stable_level,

    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bdc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bdc_pkg::DATA_W-1:0]  pwdata,
    output logic [bdc_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        r_active_low;
    logic [15:0] r_debounce_ms;
    logic [15:0] r_press_ms;
    logic [15:0] r_click_ms;
    logic [2:0]  r_initial_mode;

    logic              cfg_wr;
    bdc_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = bdc_pkg::t_reg_idx'(paddr[bdc_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low   <= bdc_pkg::RST_ACTIVE_LOW;
            r_debounce_ms  <= bdc_pkg::RST_DEBOUNCE_MS;
            r_press_ms     <= bdc_pkg::RST_PRESS_MS;
            r_click_ms     <= bdc_pkg::RST_CLICK_MS;
            r_initial_mode <= bdc_pkg::RST_INITIAL_MODE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bdc_pkg::REG_ACTIVE_LOW:   r_active_low   <= pwdata[0];
                bdc_pkg::REG_DEBOUNCE_MS:  r_debounce_ms  <= pwdata[15:0];
                bdc_pkg::REG_PRESS_MS:     r_press_ms     <= pwdata[15:0];
                bdc_pkg::REG_CLICK_MS:     r_click_ms     <= pwdata[15:0];
                bdc_pkg::REG_INITIAL_MODE: r_initial_mode <= pwdata[2:0];
                default: ; // unmapped index: drop the write
            endcase
        end
    end

    // Readback of the register under paddr
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            bdc_pkg::REG_ACTIVE_LOW:   prdata = bdc_pkg::DATA_W'(r_active_low);
            bdc_pkg::REG_DEBOUNCE_MS:  prdata = bdc_pkg::DATA_W'(r_debounce_ms);
            bdc_pkg::REG_PRESS_MS:     prdata = bdc_pkg::DATA_W'(r_press_ms);
            bdc_pkg::REG_CLICK_MS:     prdata = bdc_pkg::DATA_W'(r_click_ms);
            bdc_pkg::REG_INITIAL_MODE: prdata = bdc_pkg::DATA_W'(r_initial_mode);
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: input register feeds result register
    // ---------------------------------------------------------------
    logic                 r_in_vld;
    logic                 r_raw;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_out_vld;
    logic                 adv;      // input stage moves into the result register
    logic                 in_acc;
    logic                 fire;     // a poll is evaluated and committed this cycle

    assign adv        = ~r_out_vld | ~i_out_stall;
    assign o_in_stall = r_in_vld & ~adv;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign fire       = r_in_vld & adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    // Payload of the input register; only the low TIME_BITS of time matter
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_raw <= i_raw_level;
            r_now <= TIME_BITS'(i_now_ms);
        end
    end

    // ---------------------------------------------------------------
    // Detector state
    // ---------------------------------------------------------------
    bdc_pkg::t_mode       r_mode,        n_mode;
    logic                 r_stable,      n_stable;
    logic                 r_prev_raw;
    logic [TIME_BITS-1:0] r_last_change, n_last_change;
    logic [TIME_BITS-1:0] r_start,       n_start;
    bdc_pkg::t_events     n_ev;

    logic                 raw_chg;
    logic [TIME_BITS-1:0] el_db;
    logic [TIME_BITS-1:0] el_st;
    logic                 is_pressed;
    logic                 press_over;
    logic                 click_over;

    // Debounce: a fresh edge restarts the hold timer, whose elapsed time is then
    // zero, so only an unchanged raw level can pass the threshold.
    assign raw_chg       = r_raw ^ r_prev_raw;
    assign el_db         = r_now - r_last_change;
    assign n_last_change = raw_chg ? r_now : r_last_change;
    assign n_stable      = (~raw_chg && (el_db > TIME_BITS'(r_debounce_ms))) ? r_raw : r_stable;

    // Pressed level is low when active_low is set
    assign is_pressed = (n_stable == ~r_active_low);

    // Wrapping elapsed time since the current mode started
    assign el_st      = r_now - r_start;
    assign press_over = el_st > TIME_BITS'(r_press_ms);
    assign click_over = el_st > TIME_BITS'(r_click_ms);

    // Click machine: next mode, start time and events of this poll
    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_ev    = '0;
        unique case (r_mode)
            bdc_pkg::MODE_RELEASED: begin
                if (is_pressed) begin
                    n_mode  = bdc_pkg::MODE_PRESSED;
                    n_start = r_now;
                end
            end
            bdc_pkg::MODE_PRESSED: begin
                if (!is_pressed) begin
                    n_mode  = bdc_pkg::MODE_PRESS_REL;
                    n_start = r_now;
                end else if (press_over) begin
                    // held from the released side: long press
                    n_ev.long_pressed = 1'b1;
                    n_ev.switched     = 1'b1;
                    n_mode            = bdc_pkg::MODE_HELD;
                end
            end
            bdc_pkg::MODE_PRESS_REL: begin
                if (click_over) begin
                    n_ev.clicked = 1'b1;
                    n_mode       = bdc_pkg::MODE_RELEASED;
                end else if (is_pressed) begin
                    n_mode  = bdc_pkg::MODE_SECOND_PRESS;
                    n_start = r_now;
                end
            end
            bdc_pkg::MODE_SECOND_PRESS: begin
                if (click_over) begin
                    n_ev.double_clicked = 1'b1;
                    n_mode              = bdc_pkg::MODE_HELD;
                end else if (!is_pressed) begin
                    n_ev.double_clicked = 1'b1;
                    n_mode              = bdc_pkg::MODE_RELEASED;
                end
            end
            bdc_pkg::MODE_HELD: begin
                if (!is_pressed) begin
                    n_mode  = bdc_pkg::MODE_HELD_REL;
                    n_start = r_now;
                end
            end
            bdc_pkg::MODE_HELD_REL: begin
                if (is_pressed) begin
                    n_mode  = bdc_pkg::MODE_HELD_REPRESS;
                    n_start = r_now;
                end else if (press_over) begin
                    // released from the held side: long release
                    n_ev.long_released = 1'b1;
                    n_ev.switched      = 1'b1;
                    n_mode             = bdc_pkg::MODE_RELEASED;
                end
            end
            bdc_pkg::MODE_HELD_REPRESS: begin
                if (click_over) begin
                    n_ev.clicked = 1'b1;
                    n_mode       = bdc_pkg::MODE_HELD;
                end else if (!is_pressed) begin
                    n_mode  = bdc_pkg::MODE_SECOND_REL;
                    n_start = r_now;
                end
            end
            bdc_pkg::MODE_SECOND_REL: begin
                if (click_over) begin
                    n_ev.double_clicked = 1'b1;
                    n_mode              = bdc_pkg::MODE_RELEASED;
                end else if (is_pressed) begin
                    n_ev.double_clicked = 1'b1;
                    n_mode              = bdc_pkg::MODE_HELD;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // State register; a write of initial_mode loads the mode directly (the user must
    // write configuration only while no poll is in flight; the block does not enforce it)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= bdc_pkg::MODE_RELEASED;
            r_stable      <= bdc_pkg::RST_ACTIVE_LOW;
            r_prev_raw    <= bdc_pkg::RST_ACTIVE_LOW;
            r_last_change <= '0;
            r_start       <= '0;
        end else if (cfg_wr && cfg_idx == bdc_pkg::REG_INITIAL_MODE) begin
            r_mode <= bdc_pkg::t_mode'(pwdata[2:0]);
        end else if (fire) begin
            r_mode        <= n_mode;
            r_stable      <= n_stable;
            r_prev_raw    <= r_raw;
            r_last_change <= n_last_change;
            r_start       <= n_start;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    bdc_pkg::t_events r_ev;
    bdc_pkg::t_mode   r_out_mode;
    logic             r_out_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ev         <= n_ev;
            r_out_mode   <= n_mode;
            r_out_stable <= n_stable;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_clicked        = r_ev.clicked;
    assign o_double_clicked = r_ev.double_clicked;
    assign o_long_pressed   = r_ev.long_pressed;
    assign o_long_released  = r_ev.long_released;
    assign o_switched       = r_ev.switched;
    assign o_any_event      = |r_ev;
    assign o_mode           = r_out_mode;
    assign o_stable_level   = r_out_stable;

`ifndef ASSERT_OFF
    // A long press always lands in the held mode
    a_lp_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_ev.long_pressed) |-> (r_out_mode == bdc_pkg::MODE_HELD))
        else $error("long press without held mode");

    // A long release always lands in the released mode
    a_lr_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_ev.long_released) |-> (r_out_mode == bdc_pkg::MODE_RELEASED))
        else $error("long release without released mode");

    // Click kinds are mutually exclusive within one word
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $onehot0({r_ev.clicked, r_ev.double_clicked,
                                r_ev.long_pressed, r_ev.long_released}))
        else $error("more than one click kind in one word");

    // A switch event comes only with a long press or long release
    a_sw_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_ev.switched) |-> (r_ev.long_pressed || r_ev.long_released))
        else $error("switch without long press or release");

    // A held input word is neither dropped nor overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> (r_in_vld && $stable(r_now) && $stable(r_raw)))
        else $error("input stage lost a held word");
`endif

endmodule

`default_nettype wire
